@@ hw/rtl/bmrq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte message ring queue package
// Shared opcode and result codes, the command record passed from the front
// end to the execution engine, and the configuration write record.
// ----------------------------------------------------------------------------
package bmrq_pkg;

   localparam int SIZE_W  = 9;
   localparam int LEN_W   = 7;
   localparam int BYTE_W  = 8;
   localparam int CSR_DW  = 32;
   localparam int CSR_AW  = 3;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      KIND_BYTE        = 3'd0,
      KIND_PUSH_OK     = 3'd1,
      KIND_PUSH_REJECT = 3'd2,
      KIND_PULL_REJECT = 3'd3,
      KIND_CLEARED     = 3'd4
   } kind_type;

   // Register index of queue_size in the register list.
   localparam logic REG_QUEUE_SIZE = 1'b0;

   typedef struct packed {
      op_type              op;
      logic [LEN_W-1:0]    len;
      logic [BYTE_W-1:0]   data;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmdq_type;

   typedef struct packed {
      logic              wr;
      logic [SIZE_W-1:0] size;
   } cfg_write_type;

   typedef struct packed {
      logic              strobe;
      kind_type          kind;
      logic [BYTE_W-1:0] out_byte;
      logic [SIZE_W-1:0] moved;
      logic [SIZE_W-1:0] fill;
      logic [SIZE_W-1:0] space;
      logic              last;
   } rsp_type;

endpackage

@@ hw/rtl/bmrq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte message ring queue front end
// Accepts request transactions, decodes the opcode, caps the pull length and
// holds the commands in a four-entry queue for the execution engine.
// ----------------------------------------------------------------------------
module bmrq_front #(
   parameter int MAX_PULL = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_opcode,
   input  logic [6:0]                req_pull_length,
   input  logic [7:0]                req_push_byte,
   input  logic                      req_run_end,
   output bmrq_pkg::cmdq_type        cmdq,
   input  logic                      pop
);
   import bmrq_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam logic [LEN_W-1:0] PULL_CAP = LEN_W'(MAX_PULL);
   localparam logic [QAW:0]     FULL_CNT = (QAW+1)'(QDEPTH);

   cmd_type          queue_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;
   logic             accept;
   logic             enq;
   logic             deq;
   logic             known_op;
   cmd_type          new_cmd;

   assign busy   = (count_ff == FULL_CNT);
   assign accept = start && !busy;

   always_comb begin
      known_op     = 1'b1;
      new_cmd.op   = OP_PUSH;
      unique case (req_opcode)
         OP_PUSH:  new_cmd.op = OP_PUSH;
         OP_PULL:  new_cmd.op = OP_PULL;
         OP_CLEAR: new_cmd.op = OP_CLEAR;
         default:  known_op   = 1'b0;
      endcase
      new_cmd.len  = (req_pull_length > PULL_CAP) ? PULL_CAP : req_pull_length;
      new_cmd.data = req_push_byte;
      new_cmd.last = req_run_end;
   end

   // The unused opcode is taken from the requester and then forgotten.
   assign enq = accept && known_op;
   assign deq = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QAW+1)'(enq) - (QAW+1)'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmdq.valid = (count_ff != '0);
   assign cmdq.cmd   = queue_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("command queue count exceeds its depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty command queue with unequal pointers");

endmodule

@@ hw/rtl/bmrq_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte message ring queue execution engine
// Runs queued commands against the byte ring: speculative push writes with
// commit or drop at the end of a run, byte-per-cycle pulls, and clears.
// Holds the size register and the registered result transaction.
// ----------------------------------------------------------------------------
module bmrq_engine #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bmrq_pkg::cmdq_type       cmdq,
   output logic                     pop,
   input  bmrq_pkg::cfg_write_type  cfg,
   output logic [8:0]               size_out,
   output bmrq_pkg::rsp_type        rsp
);
   import bmrq_pkg::*;

   // The size register never exceeds 511, so deeper stores are never used.
   localparam int MEM_DEPTH = (DEPTH < 512) ? DEPTH : 512;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam logic [16:0] DEPTH_LIM = 17'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_PULL = 2'b10
   } state_type;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
                                              input logic [SIZE_W-1:0] qs);
      logic [SIZE_W:0] n;
      n = (SIZE_W+1)'(p) + 1'b1;
      if (n >= {1'b0, qs}) return '0;
      return AW'(n);
   endfunction

   logic [BYTE_W-1:0]  mem [MEM_DEPTH];
   logic [BYTE_W-1:0]  rd_data_ff;

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [AW-1:0]      rp_ff, rp_in;
   logic [AW-1:0]      spec_ff, spec_in;
   logic [SIZE_W-1:0]  stored_ff, stored_in;
   logic [SIZE_W-1:0]  run_len_ff, run_len_in;
   logic               ovf_ff, ovf_in;
   logic [LEN_W-1:0]   pull_len_ff, pull_len_in;
   logic [LEN_W-1:0]   pull_cnt_ff, pull_cnt_in;

   logic               strobe_ff, strobe_in;
   kind_type           kind_ff, kind_in;
   logic [SIZE_W-1:0]  moved_ff, moved_in;
   logic [SIZE_W-1:0]  fill_ff, fill_in;
   logic [SIZE_W-1:0]  space_ff, space_in;
   logic               last_ff, last_in;

   logic               mem_we;
   logic [SIZE_W-1:0]  free_space;
   logic               can_write;
   logic [SIZE_W-1:0]  run_len_new;
   logic               ovf_new;
   logic [AW-1:0]      spec_new;
   logic [LEN_W-1:0]   cur_len;
   logic [LEN_W-1:0]   next_cnt;
   logic               emit;

   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      spec_in     = spec_ff;
      stored_in   = stored_ff;
      run_len_in  = run_len_ff;
      ovf_in      = ovf_ff;
      pull_len_in = pull_len_ff;
      pull_cnt_in = pull_cnt_ff;
      strobe_in   = 1'b0;
      kind_in     = kind_ff;
      moved_in    = '0;
      last_in     = 1'b1;
      pop         = 1'b0;
      mem_we      = 1'b0;
      emit        = 1'b0;

      free_space  = size_ff - stored_ff;
      can_write   = !ovf_ff && (run_len_ff < free_space);
      run_len_new = run_len_ff + SIZE_W'(can_write);
      ovf_new     = ovf_ff || !can_write;
      spec_new    = can_write ? wrap_inc(spec_ff, size_ff) : spec_ff;
      cur_len     = (state_ff == ST_PULL) ? pull_len_ff : cmdq.cmd.len;
      next_cnt    = ((state_ff == ST_PULL) ? pull_cnt_ff : '0) + 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmdq.valid) begin
               pop = 1'b1;
               case (cmdq.cmd.op)
                  OP_PUSH: begin
                     mem_we = can_write;
                     if (cmdq.cmd.last) begin
                        strobe_in  = 1'b1;
                        run_len_in = '0;
                        ovf_in     = 1'b0;
                        if (!ovf_new && (run_len_new != '0)) begin
                           wp_in     = spec_new;
                           spec_in   = spec_new;
                           stored_in = stored_ff + run_len_new;
                           kind_in   = KIND_PUSH_OK;
                           moved_in  = run_len_new;
                        end else begin
                           spec_in = wp_ff;
                           kind_in = KIND_PUSH_REJECT;
                        end
                     end else begin
                        run_len_in = run_len_new;
                        ovf_in     = ovf_new;
                        spec_in    = spec_new;
                     end
                  end
                  OP_PULL: begin
                     if ((cmdq.cmd.len == '0) || (SIZE_W'(cmdq.cmd.len) > stored_ff)
                         || (size_ff == '0)) begin
                        strobe_in = 1'b1;
                        kind_in   = KIND_PULL_REJECT;
                     end else begin
                        emit = 1'b1;
                        if (cmdq.cmd.len != next_cnt) begin
                           state_in    = ST_PULL;
                           pull_len_in = cmdq.cmd.len;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     wp_in      = '0;
                     rp_in      = '0;
                     spec_in    = '0;
                     stored_in  = '0;
                     run_len_in = '0;
                     ovf_in     = 1'b0;
                     strobe_in  = 1'b1;
                     kind_in    = KIND_CLEARED;
                  end
                  default: ;
               endcase
            end
         end
         ST_PULL: begin
            emit = 1'b1;
            if (next_cnt == pull_len_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // One pulled byte per cycle; the byte itself arrives from the memory
      // read register together with the rest of the result.
      if (emit) begin
         strobe_in   = 1'b1;
         kind_in     = KIND_BYTE;
         moved_in    = SIZE_W'(next_cnt);
         last_in     = (next_cnt == cur_len);
         stored_in   = stored_ff - 1'b1;
         rp_in       = wrap_inc(rp_ff, size_ff);
         pull_cnt_in = next_cnt;
      end

      // A size write empties the queue and drops any pending push run.
      if (cfg.wr) begin
         size_in    = ({8'd0, cfg.size} <= DEPTH_LIM) ? cfg.size : '0;
         wp_in      = '0;
         rp_in      = '0;
         spec_in    = '0;
         stored_in  = '0;
         run_len_in = '0;
         ovf_in     = 1'b0;
      end

      fill_in  = stored_in;
      space_in = size_in - stored_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         size_ff     <= '0;
         wp_ff       <= '0;
         rp_ff       <= '0;
         spec_ff     <= '0;
         stored_ff   <= '0;
         run_len_ff  <= '0;
         ovf_ff      <= 1'b0;
         pull_len_ff <= '0;
         pull_cnt_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         size_ff     <= size_in;
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         spec_ff     <= spec_in;
         stored_ff   <= stored_in;
         run_len_ff  <= run_len_in;
         ovf_ff      <= ovf_in;
         pull_len_ff <= pull_len_in;
         pull_cnt_ff <= pull_cnt_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      moved_ff <= moved_in;
      fill_ff  <= fill_in;
      space_ff <= space_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[spec_ff] <= cmdq.cmd.data;
      end
      rd_data_ff <= mem[rp_ff];
   end

   assign size_out     = size_ff;
   assign rsp.strobe   = strobe_ff;
   assign rsp.kind     = kind_ff;
   assign rsp.out_byte = (kind_ff == KIND_BYTE) ? rd_data_ff : '0;
   assign rsp.moved    = moved_ff;
   assign rsp.fill     = fill_ff;
   assign rsp.space    = space_ff;
   assign rsp.last     = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (stored_ff + run_len_ff) <= size_ff)
      else $error("stored and pending bytes exceed the queue size");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PULL) |-> (pull_cnt_ff < pull_len_ff) && !pop)
      else $error("pull sequencer out of range or popping while pulling");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PULL) |=> strobe_ff && (kind_ff == KIND_BYTE))
      else $error("pull cycle without a pulled byte result");

endmodule

@@ hw/rtl/byte_message_ring_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte message ring queue
// All-or-nothing byte ring queue with a programmable active size.
// ----------------------------------------------------------------------------
// Requests are command transactions taken when start is high and busy is low:
// push bytes (a run closed by req_run_end), pulls of req_pull_length bytes,
// and clears. Results appear on the rsp_ ports for one cycle each, marked by
// rsp_strobe; the receiver cannot hold them off.
// A four-entry command queue separates the request side from the engine, so
// busy only rises when that queue is full. A taken command is registered in
// that queue and reaches the engine once the engine is idle; its results come
// from the engine's result registers. Push bytes, clears and rejections are
// handled without stalling the engine; a pull of n bytes gives n results, one
// per cycle, limited by the single read port of the byte store.
// The size register sits at address 0 of the APB-style port; writing it
// empties the queue. After reset the size is zero, so the queue is closed
// until software programs a size. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module byte_message_ring_queue_core #(
   parameter int DEPTH    = 256,
   parameter int MAX_PULL = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [6:0]  req_pull_length,
   input  logic [7:0]  req_push_byte,
   input  logic        req_run_end,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [8:0]  rsp_moved_count,
   output logic [8:0]  rsp_fill_level,
   output logic [8:0]  rsp_space_left,
   output logic        rsp_final_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bmrq_pkg::*;

   cmdq_type      cmdq;
   logic          pop;
   cfg_write_type cfg;
   logic [8:0]    size_reg;
   rsp_type       rsp;
   logic          reg_sel;

   bmrq_front #(
      .MAX_PULL (MAX_PULL)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_pull_length (req_pull_length),
      .req_push_byte   (req_push_byte),
      .req_run_end     (req_run_end),
      .cmdq            (cmdq),
      .pop             (pop)
   );

   bmrq_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmdq     (cmdq),
      .pop      (pop),
      .cfg      (cfg),
      .size_out (size_reg),
      .rsp      (rsp)
   );

   // paddr[2] selects the register word; only the first one exists.
   assign reg_sel  = (paddr[2] == REG_QUEUE_SIZE);
   assign pready   = 1'b1;
   assign cfg.wr   = psel && penable && pwrite && pready && reg_sel;
   assign cfg.size = pwdata[SIZE_W-1:0];
   assign prdata   = reg_sel ? {{(CSR_DW-SIZE_W){1'b0}}, size_reg} : '0;

   assign rsp_strobe       = rsp.strobe;
   assign rsp_kind         = rsp.kind;
   assign rsp_out_byte     = rsp.out_byte;
   assign rsp_moved_count  = rsp.moved;
   assign rsp_fill_level   = rsp.fill;
   assign rsp_space_left   = rsp.space;
   assign rsp_final_result = rsp.last;

endmodule
